/* hdl/cbvs_pkg.sv */
// ----------------------------------------------------------------------------
// cbvs_pkg
// shared types, constants and helpers of the bezier value smoother
// ----------------------------------------------------------------------------
package cbvs_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned T_FRAC  = 16;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned TICK_W  = 16;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_SET  = 2'd1;
  localparam logic [1:0] MODE_SNAP = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_T_START,
    OP_T_TAKE,
    OP_P1_START,
    OP_P1_TAKE,
    OP_MUL_UU,
    OP_SET_U2,
    OP_MUL_U2U,
    OP_SET_U3,
    OP_MUL_U2T,
    OP_SET_W1,
    OP_MUL_UT,
    OP_SET_UT,
    OP_MUL_V0,
    OP_ACC_V0,
    OP_MUL_V1,
    OP_MUL_S0,
    OP_ACC_S0,
    OP_MUL_S1,
    OP_ACC_ADD,
    OP_SLOPE_STORE,
    OP_UPDATE,
    OP_OUT_CURVE,
    OP_OUT_DIRECT
  } op_t;

  typedef struct packed {
    logic latch;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic have_t;
    logic have_p;
    logic t_full;
    logic div_done;
    logic out_free;
    logic mode_set;
  } status_t;

  function automatic logic [VALUE_W-1:0] sat_val(input logic [ACC_W-1:0] x);
    logic [VALUE_W-1:0] r;
    if ((&x[ACC_W-1:VALUE_W-1]) || !(|x[ACC_W-1:VALUE_W-1])) begin
      r = x[VALUE_W-1:0];
    end else if (x[ACC_W-1]) begin
      r = {1'b1, {(VALUE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(VALUE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hdl/cbvs_div.sv */
// ----------------------------------------------------------------------------
// cbvs_div
// restoring divider, one quotient bit per cycle, 32 bit by 16 bit
// ----------------------------------------------------------------------------
module cbvs_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [15:0] rem;
  logic [15:0] dsr;
  logic [31:0] quo;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] rem_sh;
  logic [17:0] diff;
  logic        ge;

  assign rem_sh   = {rem, quo[31]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dsr};
  assign ge       = !diff[17];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[15:0] : rem_sh[15:0];
      quo <= {quo[30:0], ge};
    end
  end

endmodule

/* hdl/cbvs_datapath.sv */
// ----------------------------------------------------------------------------
// cbvs_datapath
// target state, curve weights, shared multiplier and output register
// ----------------------------------------------------------------------------
module cbvs_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  cbvs_pkg::cmd_t               cmd,
  output cbvs_pkg::status_t            status,
  input  logic [1:0]                   in_mode,
  input  logic [cbvs_pkg::VALUE_W-1:0] in_target,
  input  logic                         cfg_we,
  input  logic [cbvs_pkg::TICK_W-1:0]  cfg_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cbvs_pkg::VALUE_W-1:0] out_value,
  output logic                         out_flag
);

  localparam int unsigned VW = cbvs_pkg::VALUE_W;
  localparam int unsigned F  = cbvs_pkg::T_FRAC;
  localparam int unsigned AW = cbvs_pkg::ACC_W;
  localparam int unsigned TW = cbvs_pkg::TICK_W;
  localparam int unsigned PW = VW + 2 + F + 4;
  localparam logic [F:0]  ONE = {1'b1, {F{1'b0}}};
  // ceil(2^33 / 3), exact divide by three for any 32 bit magnitude
  localparam logic [31:0] THIRD = 32'hAAAAAAAB;

  logic [1:0]    mode;
  logic [VW-1:0] tv;
  logic [VW-1:0] tgt;
  logic [VW-1:0] prev;
  logic [VW-1:0] slope;
  logic          have_t;
  logic          have_p;
  logic [TW-1:0] elapsed;
  logic [TW-1:0] conv;
  logic [F:0]    t;
  logic [F:0]    u;
  logic [F:0]    u2;
  logic [F:0]    u3;
  logic [F:0]    ut;
  logic [F+2:0]  w1;
  logic [VW-1:0] p1;
  logic signed [PW-1:0] prod;
  logic [AW-1:0] acc;

  logic signed [VW+1:0] ma;
  logic signed [F+3:0]  mb;
  logic signed [VW:0]   d_pt;
  logic signed [VW:0]   d_1t;
  logic signed [VW:0]   d_1p;
  logic signed [VW:0]   d_t1;
  logic [AW-1:0]        prod_sh;
  logic [F+2:0]         u2x3;
  logic [F+3:0]         utx6;

  logic        div_start;
  logic [31:0] div_dvd;
  logic [15:0] div_dsr;
  logic        div_done;
  logic [31:0] div_q;
  logic [31:0] s_mag;
  logic [63:0] recip;
  logic [33:0] q_s;
  logic [33:0] p1_sum;

  assign d_pt = {prev[VW-1], prev} - {tgt[VW-1], tgt};
  assign d_1t = {p1[VW-1], p1} - {tgt[VW-1], tgt};
  assign d_1p = {p1[VW-1], p1} - {prev[VW-1], prev};
  assign d_t1 = {tgt[VW-1], tgt} - {p1[VW-1], p1};
  assign u2x3 = {1'b0, u2, 1'b0} + {2'b00, u2};
  assign utx6 = {1'b0, ut, 2'b00} + {2'b00, ut, 1'b0};
  assign prod_sh = {{(AW-(PW-F)){prod[PW-1]}}, prod[PW-1:F]};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      cbvs_pkg::OP_MUL_UU: begin
        ma = {{(VW+1-F){1'b0}}, u};
        mb = {3'b000, u};
      end
      cbvs_pkg::OP_MUL_U2U: begin
        ma = {{(VW+1-F){1'b0}}, u2};
        mb = {3'b000, u};
      end
      cbvs_pkg::OP_MUL_U2T: begin
        ma = {{(VW+1-F){1'b0}}, u2};
        mb = {3'b000, t};
      end
      cbvs_pkg::OP_MUL_UT: begin
        ma = {{(VW+1-F){1'b0}}, u};
        mb = {3'b000, t};
      end
      cbvs_pkg::OP_MUL_V0: begin
        ma = {d_pt[VW], d_pt};
        mb = {1'b0, u3 , 2'b00} >> 2;
      end
      cbvs_pkg::OP_MUL_V1: begin
        ma = {d_1t[VW], d_1t};
        mb = {1'b0, w1};
      end
      cbvs_pkg::OP_MUL_S0: begin
        ma = {d_1p[VW], d_1p};
        mb = {1'b0, u2x3};
      end
      cbvs_pkg::OP_MUL_S1: begin
        ma = {d_t1[VW], d_t1};
        mb = utx6;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign div_start = (cmd.op == cbvs_pkg::OP_T_START) && !status.t_full;
  assign div_dvd   = {elapsed, {F{1'b0}}};
  assign div_dsr   = conv;
  assign s_mag     = slope[VW-1] ? (32'd0 - slope) : slope;
  assign q_s       = slope[VW-1] ? (34'd0 - {3'b000, recip[63:33]})
                                 : {3'b000, recip[63:33]};
  assign p1_sum    = {{2{prev[VW-1]}}, prev} + q_s;

  cbvs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  assign status.have_t   = have_t;
  assign status.have_p   = have_p;
  assign status.t_full   = (conv == '0) || (elapsed >= conv);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;
  assign status.mode_set = (mode == cbvs_pkg::MODE_SET);

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt       <= '0;
      prev      <= '0;
      slope     <= '0;
      have_t    <= 1'b0;
      have_p    <= 1'b0;
      elapsed   <= '0;
      conv      <= TW'(100);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        conv <= cfg_value;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        cbvs_pkg::OP_SLOPE_STORE: begin
          slope <= cbvs_pkg::sat_val(acc);
        end
        cbvs_pkg::OP_UPDATE: begin
          case (mode)
            cbvs_pkg::MODE_TICK: begin
              if (elapsed < conv) begin
                elapsed <= elapsed + TW'(1);
              end
            end
            cbvs_pkg::MODE_SET: begin
              if (have_t) begin
                prev   <= tgt;
                have_p <= 1'b1;
              end
              tgt     <= tv;
              have_t  <= 1'b1;
              elapsed <= '0;
            end
            cbvs_pkg::MODE_SNAP: begin
              if (have_t) begin
                prev   <= tgt;
                have_p <= 1'b1;
              end
              slope <= '0;
            end
            default: begin
            end
          endcase
        end
        cbvs_pkg::OP_OUT_CURVE,
        cbvs_pkg::OP_OUT_DIRECT: begin
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode <= in_mode;
      tv   <= in_target;
    end
    case (cmd.op)
      cbvs_pkg::OP_T_START: begin
        if (status.t_full) begin
          t <= ONE;
          u <= '0;
        end
      end
      cbvs_pkg::OP_T_TAKE: begin
        t <= {1'b0, div_q[F-1:0]};
        u <= ONE - {1'b0, div_q[F-1:0]};
      end
      cbvs_pkg::OP_P1_START: recip <= 64'(s_mag) * 64'(THIRD);
      cbvs_pkg::OP_P1_TAKE: p1 <= cbvs_pkg::sat_val({{(AW-34){p1_sum[33]}}, p1_sum});
      cbvs_pkg::OP_MUL_UU,
      cbvs_pkg::OP_MUL_U2U,
      cbvs_pkg::OP_MUL_U2T,
      cbvs_pkg::OP_MUL_UT,
      cbvs_pkg::OP_MUL_V0,
      cbvs_pkg::OP_MUL_V1,
      cbvs_pkg::OP_MUL_S0,
      cbvs_pkg::OP_MUL_S1: prod <= ma * mb;
      cbvs_pkg::OP_SET_U2: u2 <= prod_sh[F:0];
      cbvs_pkg::OP_SET_U3: u3 <= prod_sh[F:0];
      cbvs_pkg::OP_SET_W1: w1 <= {1'b0, prod_sh[F:0], 1'b0} + {2'b00, prod_sh[F:0]};
      cbvs_pkg::OP_SET_UT: ut <= prod_sh[F:0];
      cbvs_pkg::OP_ACC_V0: acc <= {{(AW-VW){tgt[VW-1]}}, tgt} + prod_sh;
      cbvs_pkg::OP_ACC_S0: acc <= prod_sh;
      cbvs_pkg::OP_ACC_ADD: acc <= acc + prod_sh;
      cbvs_pkg::OP_OUT_CURVE: begin
        out_value <= cbvs_pkg::sat_val(acc);
        out_flag  <= 1'b1;
      end
      cbvs_pkg::OP_OUT_DIRECT: begin
        out_value <= have_t ? tgt : '0;
        out_flag  <= have_t;
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/cbvs_ctrl.sv */
// ----------------------------------------------------------------------------
// cbvs_ctrl
// sequencer for one item: slope, state update, curve value, result
// ----------------------------------------------------------------------------
module cbvs_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cbvs_pkg::status_t      status,
  output cbvs_pkg::cmd_t         cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_T, S_TWAIT, S_P1, S_P1WAIT,
    S_M1, S_W1, S_M2, S_W2, S_M3, S_W3, S_M4, S_W4,
    S_MA, S_AA, S_MB, S_AB, S_END, S_UPD, S_CHK
  } state_t;

  state_t state;
  logic   for_slope;

  assign in_ready  = (state == S_IDLE) && status.out_free;

  always_comb begin
    cmd.latch = in_valid && in_ready;
    case (state)
      S_T:      cmd.op = cbvs_pkg::OP_T_START;
      S_TWAIT:  cmd.op = status.div_done ? cbvs_pkg::OP_T_TAKE : cbvs_pkg::OP_NONE;
      S_P1:     cmd.op = cbvs_pkg::OP_P1_START;
      S_P1WAIT: cmd.op = cbvs_pkg::OP_P1_TAKE;
      S_M1:     cmd.op = cbvs_pkg::OP_MUL_UU;
      S_W1:     cmd.op = cbvs_pkg::OP_SET_U2;
      S_M2:     cmd.op = cbvs_pkg::OP_MUL_U2U;
      S_W2:     cmd.op = cbvs_pkg::OP_SET_U3;
      S_M3:     cmd.op = cbvs_pkg::OP_MUL_U2T;
      S_W3:     cmd.op = cbvs_pkg::OP_SET_W1;
      S_M4:     cmd.op = cbvs_pkg::OP_MUL_UT;
      S_W4:     cmd.op = cbvs_pkg::OP_SET_UT;
      S_MA:     cmd.op = for_slope ? cbvs_pkg::OP_MUL_S0 : cbvs_pkg::OP_MUL_V0;
      S_AA:     cmd.op = for_slope ? cbvs_pkg::OP_ACC_S0 : cbvs_pkg::OP_ACC_V0;
      S_MB:     cmd.op = for_slope ? cbvs_pkg::OP_MUL_S1 : cbvs_pkg::OP_MUL_V1;
      S_AB:     cmd.op = cbvs_pkg::OP_ACC_ADD;
      S_END:    cmd.op = for_slope ? cbvs_pkg::OP_SLOPE_STORE : cbvs_pkg::OP_OUT_CURVE;
      S_UPD:    cmd.op = cbvs_pkg::OP_UPDATE;
      S_CHK:    cmd.op = (status.have_t && status.have_p)
                         ? cbvs_pkg::OP_NONE : cbvs_pkg::OP_OUT_DIRECT;
      default:  cmd.op = cbvs_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      for_slope <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.latch) state <= S_START;
        end
        S_START: begin
          if (status.mode_set && status.have_p) begin
            for_slope <= 1'b1;
            state     <= S_T;
          end else begin
            state <= S_UPD;
          end
        end
        S_T:      state <= status.t_full ? S_P1 : S_TWAIT;
        S_TWAIT:  if (status.div_done) state <= S_P1;
        S_P1:     state <= S_P1WAIT;
        S_P1WAIT: state <= S_M1;
        S_M1:     state <= S_W1;
        S_W1:     state <= S_M2;
        S_M2:     state <= S_W2;
        S_W2:     state <= S_M3;
        S_M3:     state <= S_W3;
        S_W3:     state <= S_M4;
        S_M4:     state <= S_W4;
        S_W4:     state <= S_MA;
        S_MA:     state <= S_AA;
        S_AA:     state <= S_MB;
        S_MB:     state <= S_AB;
        S_AB:     state <= S_END;
        S_END:    state <= for_slope ? S_UPD : S_IDLE;
        S_UPD:    state <= S_CHK;
        S_CHK: begin
          if (status.have_t && status.have_p) begin
            for_slope <= 1'b0;
            state     <= S_T;
          end else begin
            state <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/cubic_bezier_value_smoother.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_value_smoother
// eases a q16.16 value from the previous target to the new one on a cubic
// bezier, driven by tick, set target and snap beats
// ----------------------------------------------------------------------------
// s_axis carries one item per beat: tuser = mode, tdata = target_value.
// m_axis returns one result beat per item: tdata = current_value,
// tuser = value_valid. cfg writes converge_ticks at any cfg_valid beat
// (cfg_ready is always high); write it only while the block is idle.
// a value that needs no curve is given directly; a curve point takes a
// divider pass for t plus its wait, p1 by a multiply by one third and
// 13 multiply and accumulate steps, and skips the divider once t has
// reached 1.0; a tick or snap on a curve gives one curve point, and a
// set target beat with a slope to record takes two curve points.
// one item is in flight at a time; the result sits in an output register
// and the next item is taken in the same cycle as the result appears if
// that register is being read. a stalled m_axis holds the result and
// blocks s_axis.
// reset clears all targets, slope and tick count and sets converge_ticks
// to 100.
// ----------------------------------------------------------------------------
module cubic_bezier_value_smoother (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // target_value
  input  logic [1:0]  s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // current_value
  output logic [0:0]  m_axis_tuser,   // value_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  cbvs_pkg::cmd_t    cmd;
  cbvs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  cbvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cbvs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (s_axis_tuser),
    .in_target (s_axis_tdata),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_value (m_axis_tdata),
    .out_flag  (m_axis_tuser[0])
  );

endmodule
